// ===== design/irdf_pkg.sv =====
// Shared types and constants for the infrared distance filter.
`timescale 1ns / 1ps

package irdf_pkg;

    // Default build values
    localparam int SAMPLE_BITS_DEF  = 12;
    localparam int FILTER_SHIFT_DEF = 5;

    // Fixed field widths
    localparam int CAL_BITS       = 17;
    localparam int AVG_OUT_BITS   = 17;
    localparam int DIST_BITS      = 14;
    localparam int CFG_INDEX_BITS = 3;

    // Distance codes in mm
    localparam logic [DIST_BITS-1:0] DIST_OFF = 14'd10000;
    localparam logic [DIST_BITS-1:0] DIST_MAX = 14'd1500;
    localparam int                   DIST_MIN = 50;

    // Folded calibration constants:
    // dist = K_NUM*(near-far) / (K_SLOPE*(avg-far) + K_SPAN*(near-far))
    localparam logic [CAL_BITS-1:0] K_NUM   = 17'd100000;
    localparam logic [CAL_BITS-1:0] K_SLOPE = 17'd569;
    localparam logic [CAL_BITS-1:0] K_SPAN  = 17'd200;
    localparam logic [CAL_BITS-1:0] K_LIMIT = 17'd1500;

    // Quotient bits: an in-range result never exceeds 1500
    localparam int QUOT_BITS = 11;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_POWER_ENABLE     = 3'd0,
        REG_SENSOR_INSTALLED = 3'd1,
        REG_CAL_NEAR_LEFT    = 3'd2,
        REG_CAL_FAR_LEFT     = 3'd3,
        REG_CAL_NEAR_FRONT   = 3'd4,
        REG_CAL_FAR_FRONT    = 3'd5
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILTER,
        ST_SPAN,
        ST_NUM,
        ST_DIFF,
        ST_DEN,
        ST_LIMIT,
        ST_CHECK,
        ST_DIVIDE,
        ST_STORE,
        ST_OUTPUT
    } state_t;

endpackage

// ===== design/ir_distance_filter.sv =====
`timescale 1ns / 1ps
// Two-channel infrared range estimator: leaky sum filter plus calibrated distance.
// Usage: input channel (sample_valid / sample_stall) carries one request with a
//   raw ADC sample per sensor; output channel (result_valid / result_stall)
//   returns one result per request: two distances in mm, the two leaky sums,
//   two out-of-range flags and the active status. Configuration channel
//   (cfg_valid / cfg_ready, always ready) writes register cfg_index with
//   cfg_data; write it only while no request is in flight.
// Sequence: with the sensor active, an accepted request gets one filter update,
//   then per channel the differences, four products on one shared constant
//   multiplier, the range check, an 11-step restoring divide and the store,
//   and last the output load. A clamped channel skips its divide. With the
//   sensor off or not fitted, the request goes straight to the output load.
// Handshake: sample_stall stays high until the result is loaded, so the next
//   request is taken in the cycle after the load and never during a computation.
// Reset: sums clear to zero, the filters are marked for restart, registers
//   take their documented reset values and no result is pending.
// Receiver stall: a finished result holds in the output register; the next
//   request is still accepted and computed, and waits for the register to free up.

module ir_distance_filter
#(
    parameter int SAMPLE_BITS  = irdf_pkg::SAMPLE_BITS_DEF,
    parameter int FILTER_SHIFT = irdf_pkg::FILTER_SHIFT_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [irdf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [irdf_pkg::CAL_BITS-1:0]       cfg_data,

    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  logic [SAMPLE_BITS-1:0]              sample_left,
    input  logic [SAMPLE_BITS-1:0]              sample_front,

    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [irdf_pkg::DIST_BITS-1:0]      dist_left_mm,
    output logic [irdf_pkg::DIST_BITS-1:0]      dist_front_mm,
    output logic [irdf_pkg::AVG_OUT_BITS-1:0]   avg_left_out,
    output logic [irdf_pkg::AVG_OUT_BITS-1:0]   avg_front_out,
    output logic                                range_flag_left,
    output logic                                range_flag_front,
    output logic                                sensor_active
);

    import irdf_pkg::*;

    // Leaky sum width
    localparam int AVG_BITS = SAMPLE_BITS + FILTER_SHIFT;
    localparam int WIDE_BITS = AVG_BITS + FILTER_SHIFT;
    // avg - far, signed
    localparam int DIFF_BITS = ((AVG_BITS > CAL_BITS) ? AVG_BITS : CAL_BITS) + 1;
    // near - far, signed
    localparam int SPAN_BITS = CAL_BITS + 1;
    // K_NUM * span, signed
    localparam int NUM_BITS = SPAN_BITS + CAL_BITS;
    // K_SLOPE * diff + K_SPAN * span, signed
    localparam int DEN_BITS = DIFF_BITS + 11;
    // K_LIMIT * den, signed
    localparam int LIM_BITS = DEN_BITS + 11;
    localparam int CMP_BITS = (NUM_BITS > LIM_BITS) ? NUM_BITS : LIM_BITS;
    // Shared multiplier: widest operand is the denominator
    localparam int MUL_A_BITS = DEN_BITS;
    localparam int MUL_BITS = MUL_A_BITS + CAL_BITS + 1;
    // Divider: remainder and shifted divisor, both nonnegative
    localparam int REM_BITS = NUM_BITS - 1;
    localparam int DVS_BITS = DEN_BITS - 1 + QUOT_BITS - 1;
    localparam int TRIAL_BITS = ((REM_BITS > DVS_BITS) ? REM_BITS : DVS_BITS) + 1;
    localparam int CNT_BITS = $clog2(QUOT_BITS);

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic                power_enable_reg;
    logic                power_enable_next;
    logic                sensor_installed_reg;
    logic                sensor_installed_next;
    logic [CAL_BITS-1:0] cal_near_left_reg;
    logic [CAL_BITS-1:0] cal_far_left_reg;
    logic [CAL_BITS-1:0] cal_near_front_reg;
    logic [CAL_BITS-1:0] cal_far_front_reg;
    logic                cfg_write;
    logic                active;
    logic                restart_reg;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;
    assign active    = power_enable_reg & sensor_installed_reg;

    // Next values of the two enable bits, to spot an off-to-on change
    always_comb
    begin
        power_enable_next     = power_enable_reg;
        sensor_installed_next = sensor_installed_reg;
        if (cfg_write)
        begin
            if (cfg_index == REG_POWER_ENABLE)
            begin
                power_enable_next = cfg_data[0];
            end
            if (cfg_index == REG_SENSOR_INSTALLED)
            begin
                sensor_installed_next = cfg_data[0];
            end
        end
    end

    // ---------------------------------------------------------------------
    // Sequencer and datapath registers
    // ---------------------------------------------------------------------
    state_t                        state_reg;
    state_t                        state_next;
    logic                          ch_reg;      // 0: left, 1: front
    logic [AVG_BITS-1:0]           avg_left_reg;
    logic [AVG_BITS-1:0]           avg_front_reg;
    logic [SAMPLE_BITS-1:0]        smp_left_reg;
    logic [SAMPLE_BITS-1:0]        smp_front_reg;
    logic signed [SPAN_BITS-1:0]   span_reg;
    logic signed [DIFF_BITS-1:0]   diff_reg;
    logic signed [NUM_BITS-1:0]    num_reg;
    logic signed [DEN_BITS-1:0]    acc_reg;
    logic signed [DEN_BITS-1:0]    den_reg;
    logic signed [LIM_BITS-1:0]    lim_reg;
    logic [REM_BITS-1:0]           rem_reg;
    logic [DVS_BITS-1:0]           dvs_reg;
    logic [QUOT_BITS-1:0]          quot_reg;
    logic [CNT_BITS-1:0]           cnt_reg;
    logic                          clamp_reg;
    logic [DIST_BITS-1:0]          res_dist_left_reg;
    logic [DIST_BITS-1:0]          res_dist_front_reg;
    logic                          res_flag_left_reg;
    logic                          res_flag_front_reg;
    logic                          result_valid_reg;

    // Output register
    logic [DIST_BITS-1:0]          dist_left_reg;
    logic [DIST_BITS-1:0]          dist_front_reg;
    logic [AVG_OUT_BITS-1:0]       avg_left_out_reg;
    logic [AVG_OUT_BITS-1:0]       avg_front_out_reg;
    logic                          flag_left_reg;
    logic                          flag_front_reg;
    logic                          active_out_reg;

    // ---------------------------------------------------------------------
    // Leaky sum: floor(avg * (2^S - 1) / 2^S) + sample, as (avg<<S - avg) >> S
    // ---------------------------------------------------------------------
    logic [WIDE_BITS-1:0] wide_left;
    logic [WIDE_BITS-1:0] wide_front;
    logic [AVG_BITS-1:0]  leak_left;
    logic [AVG_BITS-1:0]  leak_front;

    assign wide_left  = (WIDE_BITS'(avg_left_reg) << FILTER_SHIFT) - WIDE_BITS'(avg_left_reg);
    assign wide_front = (WIDE_BITS'(avg_front_reg) << FILTER_SHIFT) - WIDE_BITS'(avg_front_reg);
    assign leak_left  = AVG_BITS'(wide_left >> FILTER_SHIFT) + AVG_BITS'(smp_left_reg);
    assign leak_front = AVG_BITS'(wide_front >> FILTER_SHIFT) + AVG_BITS'(smp_front_reg);

    // ---------------------------------------------------------------------
    // Channel selection
    // ---------------------------------------------------------------------
    logic [AVG_BITS-1:0] avg_sel;
    logic [CAL_BITS-1:0] near_sel;
    logic [CAL_BITS-1:0] far_sel;

    assign avg_sel  = ch_reg ? avg_front_reg : avg_left_reg;
    assign near_sel = ch_reg ? cal_near_front_reg : cal_near_left_reg;
    assign far_sel  = ch_reg ? cal_far_front_reg : cal_far_left_reg;

    // ---------------------------------------------------------------------
    // Shared constant multiplier, operands chosen by the sequencer
    // ---------------------------------------------------------------------
    logic signed [MUL_A_BITS-1:0] mul_a;
    logic [CAL_BITS-1:0]          mul_b;
    logic signed [CAL_BITS:0]     mul_b_s;
    logic signed [MUL_BITS-1:0]   prod;

    assign mul_b_s = $signed({1'b0, mul_b});
    assign prod    = mul_a * mul_b_s;

    // ---------------------------------------------------------------------
    // Range check and divider step
    // ---------------------------------------------------------------------
    logic signed [CMP_BITS-1:0]   num_cmp;
    logic signed [CMP_BITS-1:0]   lim_cmp;
    logic                         clamp_now;
    logic signed [TRIAL_BITS-1:0] trial;
    logic                         trial_ok;
    logic                         final_flag;
    logic [DIST_BITS-1:0]         final_dist;
    logic                         out_load;

    assign num_cmp = CMP_BITS'(num_reg);
    assign lim_cmp = CMP_BITS'(lim_reg);

    // Clamp on a non-positive denominator, a negative numerator, or a value
    // above 1500 (num > 1500*den covers 1500 with a nonzero remainder too)
    assign clamp_now = den_reg[DEN_BITS-1] || (den_reg == '0) || num_reg[NUM_BITS-1]
                       || (num_cmp > lim_cmp);

    assign trial    = $signed(TRIAL_BITS'(rem_reg)) - $signed(TRIAL_BITS'(dvs_reg));
    assign trial_ok = ~trial[TRIAL_BITS-1];

    // Quotient below the minimum range also clamps
    assign final_flag = clamp_reg || (quot_reg < QUOT_BITS'(DIST_MIN));
    assign final_dist = final_flag ? DIST_MAX : DIST_BITS'(quot_reg);

    // Load the output register once it is free or being taken
    assign out_load = (state_reg == ST_OUTPUT) && (!result_valid_reg || !result_stall);

    // ---------------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    state_next = active ? ST_FILTER : ST_OUTPUT;
                end
            end
            ST_FILTER: state_next = ST_SPAN;
            ST_SPAN:   state_next = ST_NUM;
            ST_NUM:    state_next = ST_DIFF;
            ST_DIFF:   state_next = ST_DEN;
            ST_DEN:    state_next = ST_LIMIT;
            ST_LIMIT:  state_next = ST_CHECK;
            ST_CHECK:  state_next = clamp_now ? ST_STORE : ST_DIVIDE;
            ST_DIVIDE:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:  state_next = ch_reg ? ST_OUTPUT : ST_SPAN;
            ST_OUTPUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------------
    // Sequencer outputs: handshake and multiplier operands
    // ---------------------------------------------------------------------
    always_comb
    begin
        sample_stall = (state_reg != ST_IDLE);
        mul_a        = '0;
        mul_b        = '0;
        unique case (state_reg)
            ST_NUM:
            begin
                mul_a = MUL_A_BITS'(span_reg);
                mul_b = K_NUM;
            end
            ST_DIFF:
            begin
                mul_a = MUL_A_BITS'(diff_reg);
                mul_b = K_SLOPE;
            end
            ST_DEN:
            begin
                mul_a = MUL_A_BITS'(span_reg);
                mul_b = K_SPAN;
            end
            ST_LIMIT:
            begin
                mul_a = den_reg;
                mul_b = K_LIMIT;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Control state, configuration and filter sums
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= ST_IDLE;
            ch_reg               <= 1'b0;
            cnt_reg              <= '0;
            result_valid_reg     <= 1'b0;
            power_enable_reg     <= 1'b0;
            sensor_installed_reg <= 1'b1;
            cal_near_left_reg    <= CAL_BITS'(72300);
            cal_far_left_reg     <= CAL_BITS'(12500);
            cal_near_front_reg   <= CAL_BITS'(72300);
            cal_far_front_reg    <= CAL_BITS'(12500);
            avg_left_reg         <= '0;
            avg_front_reg        <= '0;
            restart_reg          <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;

            // Configuration writes
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_POWER_ENABLE:     power_enable_reg     <= power_enable_next;
                    REG_SENSOR_INSTALLED: sensor_installed_reg <= sensor_installed_next;
                    REG_CAL_NEAR_LEFT:    cal_near_left_reg    <= cfg_data;
                    REG_CAL_FAR_LEFT:     cal_far_left_reg     <= cfg_data;
                    REG_CAL_NEAR_FRONT:   cal_near_front_reg   <= cfg_data;
                    REG_CAL_FAR_FRONT:    cal_far_front_reg    <= cfg_data;
                    default:
                    begin
                        // drop writes to unknown registers
                    end
                endcase
                if (!active && power_enable_next && sensor_installed_next)
                begin
                    restart_reg <= 1'b1;
                end
            end

            // Filter update: seed after a restart, else leak
            if (state_reg == ST_FILTER)
            begin
                if (restart_reg)
                begin
                    avg_left_reg  <= {smp_left_reg, {FILTER_SHIFT{1'b0}}};
                    avg_front_reg <= {smp_front_reg, {FILTER_SHIFT{1'b0}}};
                    restart_reg   <= 1'b0;
                end
                else
                begin
                    avg_left_reg  <= leak_left;
                    avg_front_reg <= leak_front;
                end
            end

            // Channel and divider step counters
            if (state_reg == ST_FILTER)
            begin
                ch_reg <= 1'b0;
            end
            else if (state_reg == ST_STORE)
            begin
                ch_reg <= ~ch_reg;
            end

            if (state_reg == ST_CHECK)
            begin
                cnt_reg <= CNT_BITS'(QUOT_BITS - 1);
            end
            else if (state_reg == ST_DIVIDE)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end

            // Result handshake
            if (out_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Payload registers
    // ---------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && sample_valid)
        begin
            smp_left_reg  <= sample_left;
            smp_front_reg <= sample_front;
        end

        unique case (state_reg)
            ST_SPAN:
            begin
                span_reg <= $signed(SPAN_BITS'(near_sel)) - $signed(SPAN_BITS'(far_sel));
                diff_reg <= $signed(DIFF_BITS'(avg_sel)) - $signed(DIFF_BITS'(far_sel));
            end
            ST_NUM:
            begin
                num_reg <= NUM_BITS'(prod);
            end
            ST_DIFF:
            begin
                acc_reg <= DEN_BITS'(prod);
            end
            ST_DEN:
            begin
                den_reg <= acc_reg + DEN_BITS'(prod);
            end
            ST_LIMIT:
            begin
                lim_reg <= LIM_BITS'(prod);
            end
            ST_CHECK:
            begin
                clamp_reg <= clamp_now;
                rem_reg   <= num_reg[REM_BITS-1:0];
                dvs_reg   <= DVS_BITS'(den_reg[DEN_BITS-2:0]) << (QUOT_BITS - 1);
                quot_reg  <= '0;
            end
            ST_DIVIDE:
            begin
                // one restoring step: subtract the shifted divisor when it fits
                if (trial_ok)
                begin
                    rem_reg <= REM_BITS'(trial);
                end
                quot_reg <= {quot_reg[QUOT_BITS-2:0], trial_ok};
                dvs_reg  <= dvs_reg >> 1;
            end
            ST_STORE:
            begin
                if (ch_reg)
                begin
                    res_dist_front_reg <= final_dist;
                    res_flag_front_reg <= final_flag;
                end
                else
                begin
                    res_dist_left_reg <= final_dist;
                    res_flag_left_reg <= final_flag;
                end
            end
            default:
            begin
                // hold
            end
        endcase

        if (out_load)
        begin
            dist_left_reg     <= active ? res_dist_left_reg : DIST_OFF;
            dist_front_reg    <= active ? res_dist_front_reg : DIST_OFF;
            flag_left_reg     <= active & res_flag_left_reg;
            flag_front_reg    <= active & res_flag_front_reg;
            avg_left_out_reg  <= AVG_OUT_BITS'(avg_left_reg);
            avg_front_out_reg <= AVG_OUT_BITS'(avg_front_reg);
            active_out_reg    <= active;
        end
    end

    assign result_valid     = result_valid_reg;
    assign dist_left_mm     = dist_left_reg;
    assign dist_front_mm    = dist_front_reg;
    assign avg_left_out     = avg_left_out_reg;
    assign avg_front_out    = avg_front_out_reg;
    assign range_flag_left  = flag_left_reg;
    assign range_flag_front = flag_front_reg;
    assign sensor_active    = active_out_reg;

endmodule
